/* hdl/ycc_pkg.sv */
// Shared types and Q0.16 coefficients for the BGRA pair to YCbCr 4:2:2 converter.
package ycc_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned CoefW = 16;
  localparam int unsigned QShift = 16;
  localparam int unsigned ProdW = PixW + CoefW;
  // Signed accumulator: products plus offset stay below 2^25, one extra bit for sign.
  localparam int unsigned AccW  = ProdW + 2;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic signed [AccW-1:0] acc_t;

  // One row of the color matrix: weights, which terms subtract, and the 128 chroma offset.
  typedef struct packed {
    coef_t k_r;
    coef_t k_g;
    coef_t k_b;
    logic  neg_r;
    logic  neg_g;
    logic  neg_b;
    logic  add_ofs;
  } row_t;

  // Stage advance strobes handed to each lane.
  typedef struct packed {
    logic adv_prod;
    logic adv_sum;
  } lane_ctrl_t;

  localparam acc_t OfsQ  = acc_t'(128) <<< QShift;
  localparam acc_t MaxQ  = (acc_t'(256) <<< QShift) - acc_t'(1);

  localparam row_t RowY  = '{k_r: 16'd19595, k_g: 16'd38470, k_b: 16'd7471,
                             neg_r: 1'b0, neg_g: 1'b0, neg_b: 1'b0, add_ofs: 1'b0};
  localparam row_t RowCb = '{k_r: 16'd11058, k_g: 16'd21710, k_b: 16'd32768,
                             neg_r: 1'b1, neg_g: 1'b1, neg_b: 1'b0, add_ofs: 1'b1};
  localparam row_t RowCr = '{k_r: 16'd32768, k_g: 16'd27439, k_b: 16'd5329,
                             neg_r: 1'b0, neg_g: 1'b1, neg_b: 1'b1, add_ofs: 1'b1};

endpackage

/* hdl/ycc_lane.sv */
// One matrix-row lane: registered products, then sum, clamp and truncate.
module ycc_lane (
  input  logic                clk_i,
  input  ycc_pkg::row_t       row_i,
  input  ycc_pkg::lane_ctrl_t ctrl_i,
  input  ycc_pkg::pix_t       red_i,
  input  ycc_pkg::pix_t       green_i,
  input  ycc_pkg::pix_t       blue_i,
  output ycc_pkg::pix_t       res_o
);
  import ycc_pkg::*;

  acc_t term_r_d, term_g_d, term_b_d;
  acc_t term_r_q, term_g_q, term_b_q;
  acc_t sum;
  pix_t res_d, res_q;

  function automatic acc_t signed_term(input coef_t k, input pix_t p, input logic neg);
    logic [ProdW-1:0] prod;
    acc_t             mag;
    begin
      prod = ProdW'(k) * ProdW'(p);
      mag  = acc_t'({2'b00, prod});
      signed_term = neg ? -mag : mag;
    end
  endfunction

  always_comb begin
    term_r_d = signed_term(row_i.k_r, red_i,   row_i.neg_r);
    term_g_d = signed_term(row_i.k_g, green_i, row_i.neg_g);
    term_b_d = signed_term(row_i.k_b, blue_i,  row_i.neg_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_prod) begin
      term_r_q <= term_r_d;
      term_g_q <= term_g_d;
      term_b_q <= term_b_d;
    end
  end

  always_comb begin
    sum = term_r_q + term_g_q + term_b_q + (row_i.add_ofs ? OfsQ : acc_t'(0));
    priority if (sum < acc_t'(0)) begin
      res_d = '0;
    end else if (sum > MaxQ) begin
      res_d = '1;
    end else begin
      res_d = sum[QShift +: PixW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv_sum) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* hdl/ycc_merge.sv */
// Output stage: gathers the four lane results into one registered 4:2:2 item.
module ycc_merge (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ycc_pkg::pix_t luma_first_i,
  input  ycc_pkg::pix_t chroma_blue_i,
  input  ycc_pkg::pix_t luma_second_i,
  input  ycc_pkg::pix_t chroma_red_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ycc_pkg::pix_t luma_first_o,
  output ycc_pkg::pix_t chroma_blue_o,
  output ycc_pkg::pix_t luma_second_o,
  output ycc_pkg::pix_t chroma_red_o
);
  import ycc_pkg::*;

  logic valid_d, valid_q;
  pix_t y1_q, cb_q, y2_q, cr_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      y1_q <= luma_first_i;
      cb_q <= chroma_blue_i;
      y2_q <= luma_second_i;
      cr_q <= chroma_red_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign luma_first_o  = y1_q;
  assign chroma_blue_o = cb_q;
  assign luma_second_o = y2_q;
  assign chroma_red_o  = cr_q;

endmodule

/* hdl/bgra_pair_to_ycbcr422.sv */
// Top level: BGR pixel pair in, full-range BT.601 YCbCr 4:2:2 word out.
//
// Input channel: in_valid_i / in_ready_o with the six 8-bit color components
// of two adjacent pixels. Output channel: out_valid_o / out_ready_i with Y of
// each pixel plus Cb and Cr taken from the first pixel.
// Four lanes (Y first, Cb, Cr, Y second) run side by side; each has a
// product register stage and a sum/clamp register stage, and a final output
// register merges the lane results into one item.
// Stages: three registers (product, sum/clamp, output) lie between the input
// accept edge and out_valid_o rising; a receiver stall can hold an item in any of them.
// Throughput: one item per cycle while out_ready_i is high; each stage advances
// whenever the stage after it is empty or moving, so a new item is taken while a
// finished item waits in the output register.
// Receiver stall: items pile up in the three stages; in_ready_o drops only
// once all three hold an item. Nothing is dropped or repeated.
// Reset: clears the stage valid flags; the pipeline comes up empty and
// ready to accept in the first cycle after reset.
module bgra_pair_to_ycbcr422 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ycc_pkg::pix_t blue_first_i,
  input  ycc_pkg::pix_t green_first_i,
  input  ycc_pkg::pix_t red_first_i,
  input  ycc_pkg::pix_t blue_second_i,
  input  ycc_pkg::pix_t green_second_i,
  input  ycc_pkg::pix_t red_second_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ycc_pkg::pix_t luma_first_o,
  output ycc_pkg::pix_t chroma_blue_o,
  output ycc_pkg::pix_t luma_second_o,
  output ycc_pkg::pix_t chroma_red_o
);
  import ycc_pkg::*;

  logic       prod_vld_d, prod_vld_q;
  logic       sum_vld_d, sum_vld_q;
  logic       adv_prod, adv_sum, adv_out;
  lane_ctrl_t ctrl;
  pix_t       y1_res, cb_res, y2_res, cr_res;

  assign adv_out    = sum_vld_q && (!out_valid_o || out_ready_i);
  assign adv_sum    = prod_vld_q && (!sum_vld_q || adv_out);
  assign in_ready_o = !prod_vld_q || adv_sum;
  assign adv_prod   = in_valid_i && in_ready_o;

  assign ctrl.adv_prod = adv_prod;
  assign ctrl.adv_sum  = adv_sum;

  always_comb begin
    prod_vld_d = prod_vld_q;
    if (adv_prod) begin
      prod_vld_d = 1'b1;
    end else if (adv_sum) begin
      prod_vld_d = 1'b0;
    end
    sum_vld_d = sum_vld_q;
    if (adv_sum) begin
      sum_vld_d = 1'b1;
    end else if (adv_out) begin
      sum_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= prod_vld_d;
      sum_vld_q  <= sum_vld_d;
    end
  end

  ycc_lane u_lane_y1 (
    .clk_i   (clk_i),
    .row_i   (RowY),
    .ctrl_i  (ctrl),
    .red_i   (red_first_i),
    .green_i (green_first_i),
    .blue_i  (blue_first_i),
    .res_o   (y1_res)
  );

  ycc_lane u_lane_cb (
    .clk_i   (clk_i),
    .row_i   (RowCb),
    .ctrl_i  (ctrl),
    .red_i   (red_first_i),
    .green_i (green_first_i),
    .blue_i  (blue_first_i),
    .res_o   (cb_res)
  );

  ycc_lane u_lane_cr (
    .clk_i   (clk_i),
    .row_i   (RowCr),
    .ctrl_i  (ctrl),
    .red_i   (red_first_i),
    .green_i (green_first_i),
    .blue_i  (blue_first_i),
    .res_o   (cr_res)
  );

  ycc_lane u_lane_y2 (
    .clk_i   (clk_i),
    .row_i   (RowY),
    .ctrl_i  (ctrl),
    .red_i   (red_second_i),
    .green_i (green_second_i),
    .blue_i  (blue_second_i),
    .res_o   (y2_res)
  );

  ycc_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv_out),
    .luma_first_i  (y1_res),
    .chroma_blue_i (cb_res),
    .luma_second_i (y2_res),
    .chroma_red_i  (cr_res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .luma_first_o  (luma_first_o),
    .chroma_blue_o (chroma_blue_o),
    .luma_second_o (luma_second_o),
    .chroma_red_o  (chroma_red_o)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the BGR pixel pair to YCbCr 4:2:2 converter.
module tb_top;

  localparam int unsigned RandPairs  = 1080;
  localparam int unsigned CalmTail   = 120;   // final items run with no idling
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 12;

  // Q0.16 matrix weights
  localparam longint KYR  = 19595;
  localparam longint KYG  = 38470;
  localparam longint KYB  = 7471;
  localparam longint KCbR = 11058;
  localparam longint KCbG = 21710;
  localparam longint KCbB = 32768;
  localparam longint KCrR = 32768;
  localparam longint KCrG = 27439;
  localparam longint KCrB = 5329;
  localparam longint ChromaOfs = longint'(128) << 16;
  localparam longint SumMax    = (longint'(255) << 16) + 65535;

  typedef struct {
    ycc_pkg::pix_t b1, g1, r1, b2, g2, r2;
    int unsigned   gap;    // idle cycles before this item is offered
    bit            drain;  // hold off until all results are back
  } pair_item_t;

  typedef struct packed {
    ycc_pkg::pix_t y1;
    ycc_pkg::pix_t cb;
    ycc_pkg::pix_t y2;
    ycc_pkg::pix_t cr;
  } ycc_word_t;

  logic          clk_i          = 1'b0;
  logic          rst_ni         = 1'b0;
  logic          in_valid_i     = 1'b0;
  logic          in_ready_o;
  ycc_pkg::pix_t blue_first_i   = '0;
  ycc_pkg::pix_t green_first_i  = '0;
  ycc_pkg::pix_t red_first_i    = '0;
  ycc_pkg::pix_t blue_second_i  = '0;
  ycc_pkg::pix_t green_second_i = '0;
  ycc_pkg::pix_t red_second_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i    = 1'b0;
  ycc_pkg::pix_t luma_first_o;
  ycc_pkg::pix_t chroma_blue_o;
  ycc_pkg::pix_t luma_second_o;
  ycc_pkg::pix_t chroma_red_o;

  pair_item_t  pending_q[$];
  ycc_word_t   ycc_expect_q[$];
  pair_item_t  cur_pair;
  pair_item_t  next_pair;
  bit          have_next;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned pairs_total;
  int unsigned pairs_sent;
  int unsigned err_cnt;
  int unsigned cyc_cnt;

  bgra_pair_to_ycbcr422 u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .blue_first_i   (blue_first_i),
    .green_first_i  (green_first_i),
    .red_first_i    (red_first_i),
    .blue_second_i  (blue_second_i),
    .green_second_i (green_second_i),
    .red_second_i   (red_second_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .luma_first_o   (luma_first_o),
    .chroma_blue_o  (chroma_blue_o),
    .luma_second_o  (luma_second_o),
    .chroma_red_o   (chroma_red_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Clamp a Q16 sum to the 8-bit range, truncating the fraction.
  function automatic ycc_pkg::pix_t q16_to_pix(longint acc);
    if (acc < 0) return '0;
    if (acc > SumMax) return 8'hFF;
    return ycc_pkg::pix_t'(acc >>> 16);
  endfunction

  // Cb/Cr come from the first pixel only.
  function automatic ycc_word_t ycc_from_pair(pair_item_t p);
    ycc_word_t w;
    longint    b1, g1, r1, b2, g2, r2;
    b1 = longint'(p.b1);
    g1 = longint'(p.g1);
    r1 = longint'(p.r1);
    b2 = longint'(p.b2);
    g2 = longint'(p.g2);
    r2 = longint'(p.r2);
    w.y1 = q16_to_pix(KYR * r1 + KYG * g1 + KYB * b1);
    w.cb = q16_to_pix(ChromaOfs - KCbR * r1 - KCbG * g1 + KCbB * b1);
    w.y2 = q16_to_pix(KYR * r2 + KYG * g2 + KYB * b2);
    w.cr = q16_to_pix(ChromaOfs + KCrR * r1 - KCrG * g1 - KCrB * b1);
    return w;
  endfunction

  function automatic ycc_pkg::pix_t rand_pix();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ycc_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_pair(input ycc_pkg::pix_t b1, g1, r1, b2, g2, r2,
                          input int unsigned gap, input bit drain);
    pair_item_t p;
    p.b1 = b1; p.g1 = g1; p.r1 = r1;
    p.b2 = b2; p.g2 = g2; p.r2 = r2;
    p.gap = gap;
    p.drain = drain;
    pending_q.push_back(p);
  endtask

  task automatic check_field(input string name, input ycc_pkg::pix_t exp_v,
                             input ycc_pkg::pix_t act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Sender: one item per handshake, idle bursts taken from the item's gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      blue_first_i   <= '0;
      green_first_i  <= '0;
      red_first_i    <= '0;
      blue_second_i  <= '0;
      green_second_i <= '0;
      red_second_i   <= '0;
      have_next = 1'b0;
      gap_left  = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        ycc_expect_q.push_back(ycc_from_pair(cur_pair));
        pairs_sent++;
      end
      if (!have_next && pending_q.size() != 0) begin
        next_pair = pending_q.pop_front();
        have_next = 1'b1;
        gap_left  = next_pair.gap;
      end
      if (!have_next || gap_left != 0 ||
          (next_pair.drain && ycc_expect_q.size() != 0)) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        cur_pair = next_pair;
        have_next = 1'b0;
        in_valid_i     <= 1'b1;
        blue_first_i   <= next_pair.b1;
        green_first_i  <= next_pair.g1;
        red_first_i    <= next_pair.r1;
        blue_second_i  <= next_pair.b2;
        green_second_i <= next_pair.g2;
        red_second_i   <= next_pair.r2;
      end
    end
  end

  // Receiver: checks each item against the oldest expectation, stalls in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall_pct;
    ycc_word_t   exp_w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (ycc_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected item: expected none, got y1=%0d cb=%0d y2=%0d cr=%0d",
                   $time, luma_first_o, chroma_blue_o, luma_second_o, chroma_red_o);
        end else begin
          exp_w = ycc_expect_q.pop_front();
          check_field("luma_first", exp_w.y1, luma_first_o);
          check_field("chroma_blue", exp_w.cb, chroma_blue_o);
          check_field("luma_second", exp_w.y2, luma_second_o);
          check_field("chroma_red", exp_w.cr, chroma_red_o);
        end
      end
      // stall density rotates between none, light and heavy
      case ((cyc_cnt / 300) % 3)
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      if (pending_q.size() < CalmTail) stall_pct = 0;
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned gap_pct;
    int unsigned gap;
    // corners: black, white, chroma extremes, bit patterns
    add_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0);
    add_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1'b0);
    add_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1'b0);  // Cb max
    add_pair(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1'b0);  // Cb min
    add_pair(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 3, 1'b0);  // Cr max
    add_pair(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 0, 1'b0);  // Cr min
    add_pair(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 0, 1'b0);
    add_pair(8'h55, 8'h55, 8'h55, 8'hAA, 8'hAA, 8'hAA, 0, 1'b0);
    add_pair(8'hAA, 8'hAA, 8'hAA, 8'h55, 8'h55, 8'h55, 1, 1'b0);
    // second pixel color must not leak into chroma
    add_pair(8'h80, 8'h80, 8'h80, 8'hFF, 8'h00, 8'h00, 0, 1'b0);
    add_pair(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 0, 1'b0);
    add_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 0, 1'b0);
    add_pair(8'h01, 8'h01, 8'h01, 8'hFE, 8'hFE, 8'hFE, 0, 1'b0);
    add_pair(8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 2, 1'b0);
    add_pair(8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 0, 1'b0);
    add_pair(8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h5A, 8'hA5, 0, 1'b0);
    for (int unsigned i = 0; i < RandPairs; i++) begin
      case ((i / 150) % 3)
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (i + CalmTail >= RandPairs) gap_pct = 0;
      gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 13) : 0;
      add_pair(rand_pix(), rand_pix(), rand_pix(), rand_pix(), rand_pix(), rand_pix(),
               gap, (i == 0 || i == 400 || i == 777));
    end
    pairs_total = pending_q.size();

    while (!rst_ni) @(posedge clk_i);
    while (pairs_sent != pairs_total || ycc_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
